// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== src/bvss_pkg.sv =====
package bvss_pkg;

   // Largest number of vias in one list
   localparam int MAX_VIAS = 256;

   // Number of selection criteria
   localparam int NUM_CRIT = 6;

   // Highest index a via can get
   localparam int IDX_LIMIT_INT = (MAX_VIAS - 1 > 255) ? 255 : MAX_VIAS - 1;
   localparam logic [7:0] IDX_LIMIT = 8'(IDX_LIMIT_INT);

   // Size metric codes
   localparam logic [1:0] SIZE_AREA   = 2'd0;
   localparam logic [1:0] SIZE_WIDTH  = 2'd1;
   localparam logic [1:0] SIZE_HEIGHT = 2'd2;

   // One single-cut via
   localparam logic [7:0] ONE_CUT = 8'd1;

   typedef struct packed {
      logic [3:0]  layer_index;
      logic        is_default;
      logic [7:0]  cut_count;
      logic [19:0] via_width;
      logic [19:0] via_height;
      logic        has_resistance;
      logic [15:0] resistance;
      logic        last_via;
   } req_type;

   typedef struct packed {
      logic [3:0] out_layer;
      logic [7:0] min_area_via;
      logic [7:0] min_width_via;
      logic [7:0] min_height_via;
      logic [7:0] minres_area_via;
      logic [7:0] minres_width_via;
      logic [7:0] minres_height_via;
   } rsp_type;

   // Stored best via of one criterion
   typedef struct packed {
      logic [7:0]  index;
      logic        is_default;
      logic [7:0]  cut_count;
      logic [19:0] via_width;
      logic [19:0] via_height;
      logic [39:0] area;
      logic        has_resistance;
      logic [15:0] resistance;
   } best_type;

endpackage

// ===== src/best_via_six_way_selector.sv =====
// Output: rsp_valid is registered; it rises once the last via of a list leaves the input stage.
// Throughput: one via per cycle; each via makes one compare-and-update pass
//    against the six registered best entries, with the area product registered
//    at the input stage. A last via waits only while an untaken result is held.
// Reset: synchronous, clears the stage valid flags, the result valid and the
//    via counter; best entries are reloaded by the first via of each list.
`include "assert_macros.svh"

module best_via_six_way_selector (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bvss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bvss_pkg::rsp_type rsp_data
);

   // Input stage
   logic              s1_valid_ff, s1_valid_in;
   bvss_pkg::req_type s1_item_ff;
   logic [39:0]       s1_area_ff, s1_area_in;

   // Running state
   logic [7:0]        cnt_ff, cnt_in;
   bvss_pkg::best_type best_ff [bvss_pkg::NUM_CRIT];
   bvss_pkg::best_type best_in [bvss_pkg::NUM_CRIT];

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   bvss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              s1_adv;
   logic              req_take;
   bvss_pkg::best_type cand;

   // Compare one size metric: true when the stored best is strictly smaller
   function automatic logic size_less(input logic [1:0] metric,
                                      input bvss_pkg::best_type b,
                                      input bvss_pkg::best_type c);
      logic res;
      case (metric)
         bvss_pkg::SIZE_AREA:   res = b.area < c.area;
         bvss_pkg::SIZE_WIDTH:  res = b.via_width < c.via_width;
         bvss_pkg::SIZE_HEIGHT: res = b.via_height < c.via_height;
         default:               res = 1'b0;
      endcase
      return res;
   endfunction

   // True when the stored best is strictly better than the candidate
   function automatic logic best_wins(input logic [1:0] metric,
                                      input logic use_res,
                                      input bvss_pkg::best_type b,
                                      input bvss_pkg::best_type c);
      logic res;
      if (b.is_default && !c.is_default) begin
         res = 1'b1;
      end else if (!b.is_default && c.is_default) begin
         res = 1'b0;
      end else if (!use_res && b.cut_count == bvss_pkg::ONE_CUT &&
                   c.cut_count > bvss_pkg::ONE_CUT) begin
         res = 1'b1;
      end else if (!use_res && b.cut_count > bvss_pkg::ONE_CUT &&
                   c.cut_count == bvss_pkg::ONE_CUT) begin
         res = 1'b0;
      end else if (use_res && b.has_resistance && c.has_resistance &&
                   b.resistance != c.resistance) begin
         res = b.resistance < c.resistance;
      end else begin
         res = size_less(metric, b, c);
      end
      return res;
   endfunction

   // Handshake: a last via waits for a free result slot
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!s1_item_ff.last_via || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   // Area product for the incoming request
   assign s1_area_in = 40'(req_data.via_width) * 40'(req_data.via_height);

   // Advance the input stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Candidate entry built from the staged request
   always_comb begin
      cand.index          = cnt_ff;
      cand.is_default     = s1_item_ff.is_default;
      cand.cut_count      = s1_item_ff.cut_count;
      cand.via_width      = s1_item_ff.via_width;
      cand.via_height     = s1_item_ff.via_height;
      cand.area           = s1_area_ff;
      cand.has_resistance = s1_item_ff.has_resistance;
      cand.resistance     = s1_item_ff.resistance;
   end

   // Update all six best entries in parallel
   always_comb begin
      for (int k = 0; k < bvss_pkg::NUM_CRIT; k++) begin
         best_in[k] = best_ff[k];
         if (s1_adv && (cnt_ff == 8'd0 ||
             !best_wins(2'(k % 3), k >= 3, best_ff[k], cand))) begin
            best_in[k] = cand;
         end
      end
   end

   // Advance the via counter, saturate at the limit, drop to zero after a last via
   always_comb begin
      cnt_in = cnt_ff;
      if (s1_adv) begin
         if (s1_item_ff.last_via) begin
            cnt_in = 8'd0;
         end else if (cnt_ff < bvss_pkg::IDX_LIMIT) begin
            cnt_in = cnt_ff + 8'd1;
         end
      end
   end

   // Load the result on a last via, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv && s1_item_ff.last_via) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.out_layer         = s1_item_ff.layer_index;
         rsp_data_in.min_area_via      = best_in[0].index;
         rsp_data_in.min_width_via     = best_in[1].index;
         rsp_data_in.min_height_via    = best_in[2].index;
         rsp_data_in.minres_area_via   = best_in[3].index;
         rsp_data_in.minres_width_via  = best_in[4].index;
         rsp_data_in.minres_height_via = best_in[5].index;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         cnt_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_data;
         s1_area_ff <= s1_area_in;
      end
      for (int k = 0; k < bvss_pkg::NUM_CRIT; k++) begin
         best_ff[k] <= best_in[k];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Counter never passes the index limit
   `ASSERT_IMPLIES(a_cnt_limit, clock, reset, 1'b1, cnt_ff <= bvss_pkg::IDX_LIMIT)
   // A finished list raises the result and restarts the count
   `ASSERT_NEXT(a_last_result, clock, reset, s1_adv && s1_item_ff.last_via,
      rsp_valid_ff && cnt_ff == 8'd0)
   // A pending result is never overwritten by a stalled last via
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, rsp_valid_ff && !rsp_ready,
      !(s1_adv && s1_item_ff.last_via))

endmodule
